// ===== design/median_filter_3x3_macros.svh =====
// ---------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Concurrent check wrappers clocked on clk and disabled during arst_n reset.
// ---------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_MACROS_SVH
`define MEDIAN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MF3_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("median_filter_3x3: same-cycle check failed");

// Next-cycle implication.
`define MF3_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("median_filter_3x3: next-cycle check failed");

`else

`define MF3_ASSERT_IMPLY(name, ante, cons)
`define MF3_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== design/mf3_pkg.sv =====
// ---------------------------------------------------------------------------
// mf3_pkg
// Shared types, register codes and compare helpers of the 3x3 median filter.
// ---------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	localparam int PIX_W       = 8;
	localparam int COORD_W     = 10;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int RESET_DIM   = 256;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, sorted so that lo <= mid <= hi.
	typedef struct packed {
		pix_t hi;
		pix_t mid;
		pix_t lo;
	} col_t;

	// One line-store word: the pixels of the two lines above, same column.
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} pair_t;

	function automatic pix_t pmin(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pmax(input pix_t a, input pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return pmin(pmin(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return pmax(pmax(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return pmax(pmin(a, b), pmin(pmax(a, b), c));
	endfunction

endpackage

`default_nettype wire

// ===== design/mf3_linebuf.sv =====
// ---------------------------------------------------------------------------
// mf3_linebuf
// Line store holding the upper and middle line pixels of each column.
// ---------------------------------------------------------------------------
`default_nettype none

module mf3_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic            clk,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output mf3_pkg::pair_t       rd_data,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire mf3_pkg::pair_t  wr_data
);
	import mf3_pkg::*;

	pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/mf3_cell.sv =====
// ---------------------------------------------------------------------------
// mf3_cell
// Window column cell: sort an incoming column of three and hold it.
// ---------------------------------------------------------------------------
`default_nettype none

module mf3_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire mf3_pkg::col_t col_in,
	output mf3_pkg::col_t      col_q
);
	import mf3_pkg::*;

	pix_t l1;
	pix_t h1;
	pix_t m2;
	col_t sorted;

	// three compare-exchange steps
	always_comb begin
		l1         = pmin(col_in.lo, col_in.mid);
		h1         = pmax(col_in.lo, col_in.mid);
		sorted.hi  = pmax(h1, col_in.hi);
		m2         = pmin(h1, col_in.hi);
		sorted.lo  = pmin(l1, m2);
		sorted.mid = pmax(l1, m2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= sorted;
		end
	end

endmodule

`default_nettype wire

// ===== design/mf3_select.sv =====
// ---------------------------------------------------------------------------
// mf3_select
// Median of nine from three sorted columns, two register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module mf3_select (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire mf3_pkg::col_t col_a,
	input  wire mf3_pkg::col_t col_b,
	input  wire mf3_pkg::col_t col_c,
	output mf3_pkg::pix_t      median_q
);
	import mf3_pkg::*;

	pix_t lo_s3;
	pix_t mi_s3;
	pix_t hi_s3;

	// largest minimum, median of middles, smallest maximum
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3    <= max3(col_a.lo, col_b.lo, col_c.lo);
			mi_s3    <= med3(col_a.mid, col_b.mid, col_c.mid);
			hi_s3    <= min3(col_a.hi, col_b.hi, col_c.hi);
			median_q <= med3(lo_s3, mi_s3, hi_s3);
		end
	end

endmodule

`default_nettype wire

// ===== design/median_filter_3x3.sv =====
// ---------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter over 8-bit grayscale frames in raster order.
// ---------------------------------------------------------------------------
// Pixels enter on the s_axis channel, one item per clock at full rate, and
// one result item leaves on m_axis for every interior pixel (border pixels
// give nothing). A result passes the stage 1, column cell, select and output
// registers; the sustained rate is one pixel per cycle, set by the single
// line-store port pair (one read at accept, one write when stage 1 advances)
// and the chain of three window column cells that shifts once per pixel. The
// output register decouples the two sides: a new pixel is taken whenever the
// output register is empty or being drained. Frame size comes from image_width
// and image_height (register indexes 0 and 1 on the cfg port), each clamped
// to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; write them only while the block is
// idle. Counters wrap at the end of each line and frame, so frames follow
// back to back. The line store needs no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none
`include "median_filter_3x3_macros.svh"

module median_filter_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// pixel stream in; tdata[7:0] pixel
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [mf3_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// result stream out; tdata[7:0] median, [17:8] center_x, [27:18] center_y
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [mf3_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
	output logic                                     m_axis_tlast,
	// register writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mf3_pkg::CFG_W-1:0]           cfg_data
);
	import mf3_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int XW    = (CW > COORD_W) ? CW : COORD_W;
	localparam int YW    = (RW > COORD_W) ? RW : COORD_W;
	localparam int WIDE  = CFG_W + ((CW > RW) ? CW : RW) + 1;
	localparam int RST_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
	localparam int RST_H = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;
	localparam int PAD_W = OUT_TDATA_W - PIX_W - 2 * COORD_W;

	// ---------------- configuration ----------------
	logic [CW-1:0]   w_last_q;
	logic [RW-1:0]   h_last_q;
	logic [CW-1:0]   w_last_d;
	logic [RW-1:0]   h_last_d;
	logic [WIDE-1:0] cfg_wide;

	assign cfg_ready = 1'b1;
	assign cfg_wide  = WIDE'(cfg_data);

	// clamp the written size and keep its last index
	always_comb begin
		if (cfg_wide < WIDE'(3)) begin
			w_last_d = CW'(2);
		end else if (cfg_wide > WIDE'(MAX_WIDTH)) begin
			w_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_d = CW'(cfg_wide - WIDE'(1));
		end
		if (cfg_wide < WIDE'(3)) begin
			h_last_d = RW'(2);
		end else if (cfg_wide > WIDE'(MAX_HEIGHT)) begin
			h_last_d = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last_d = RW'(cfg_wide - WIDE'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(RST_W - 1);
			h_last_q <= RW'(RST_H - 1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_last_q <= w_last_d;
				REG_IMAGE_HEIGHT: h_last_q <= h_last_d;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic adv;
	logic accept;
	logic out_valid_q;

	// the whole pipe advances unless a finished result is held up
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// ---------------- raster counters ----------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_last;
	logic          row_last;
	logic          emit;
	logic [XW-1:0] cx_wide;
	logic [YW-1:0] cy_wide;

	assign col_last = col_q >= w_last_q;
	assign row_last = row_q >= h_last_q;
	assign emit     = (col_q >= CW'(2)) && (row_q >= RW'(2));
	assign cx_wide  = XW'(col_q) - XW'(1);
	assign cy_wide  = YW'(row_q) - YW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- stage 1: line-store read ----------------
	logic                v_s1;
	logic                emit_s1;
	logic                last_s1;
	logic [COORD_W-1:0]  cx_s1;
	logic [COORD_W-1:0]  cy_s1;
	logic [CW-1:0]       addr_s1;
	pix_t                px_s1;
	pair_t               rd_s1;
	pair_t               wr_data;
	logic                shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			emit_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= col_last && row_last;
			cx_s1   <= cx_wide[COORD_W-1:0];
			cy_s1   <= cy_wide[COORD_W-1:0];
			addr_s1 <= col_q;
			px_s1   <= s_axis_tdata[PIX_W-1:0];
		end
	end

	// push the column down one line: middle moves to upper, new pixel to middle
	assign shift   = adv && v_s1;
	assign wr_data = '{upper: rd_s1.middle, middle: px_s1};

	mf3_linebuf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_s1),
		.wr_en   (shift),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	// ---------------- stage 2: window column cells ----------------
	col_t col_new;
	col_t col_c0;
	col_t col_c1;
	col_t col_c2;

	assign col_new = '{hi: rd_s1.upper, mid: rd_s1.middle, lo: px_s1};

	mf3_cell u_cell0 (.clk(clk), .en(shift), .col_in(col_new), .col_q(col_c0));
	mf3_cell u_cell1 (.clk(clk), .en(shift), .col_in(col_c0),  .col_q(col_c1));
	mf3_cell u_cell2 (.clk(clk), .en(shift), .col_in(col_c1),  .col_q(col_c2));

	logic               e_s2;
	logic               last_s2;
	logic [COORD_W-1:0] cx_s2;
	logic [COORD_W-1:0] cy_s2;
	logic               e_s3;
	logic               last_s3;
	logic [COORD_W-1:0] cx_s3;
	logic [COORD_W-1:0] cy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_s2        <= 1'b0;
			e_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			e_s2        <= v_s1 && emit_s1;
			e_s3        <= e_s2;
			out_valid_q <= e_s3;
		end
	end

	// ---------------- stage 3 and output: median select ----------------
	pix_t               median_q;
	logic               last_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;

	mf3_select u_select (
		.clk      (clk),
		.en       (adv),
		.col_a    (col_c0),
		.col_b    (col_c1),
		.col_c    (col_c2),
		.median_q (median_q)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			last_s3 <= last_s2;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			last_q  <= last_s3;
			cx_q    <= cx_s3;
			cy_q    <= cy_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {PAD_W'(0), cy_q, cx_q, median_q};

	// ---------------- checks ----------------
	`MF3_ASSERT_IMPLY(a_ready_when_empty, !out_valid_q, s_axis_tready)
	`MF3_ASSERT_IMPLY(a_col_in_store, 1'b1, col_q <= CW'(MAX_WIDTH - 1))
	`MF3_ASSERT_NEXT(a_col_wraps, accept && col_last, col_q == '0)
	`MF3_ASSERT_NEXT(a_row_holds, accept && !col_last, $stable(row_q))

endmodule

`default_nettype wire
